### rtl/core/wfrot_pkg.sv
`timescale 1ns / 1ps

package wfrot_pkg;

   // Map geometry and input field widths.
   localparam int MAX_MAP_SIDE = 1024;
   localparam int COL_W        = $clog2(MAX_MAP_SIDE);
   localparam int MAP_W        = COL_W + 1;
   localparam int DIFF_W       = COL_W + 2;
   localparam int HEIGHT_W     = 16;
   localparam int SCALE_W      = 8;
   localparam int FACTOR_W     = 8;
   localparam int HZ_W         = HEIGHT_W + FACTOR_W;
   localparam int XS_W         = DIFF_W + SCALE_W + 1;
   localparam int ZS_W         = HZ_W + SCALE_W + 1;
   localparam int COORD_W      = 32;

   // Angle format and the quarter-wave sine table.
   localparam int ANGLE_STEPS   = 1024;
   localparam int ANGLE_W       = $clog2(ANGLE_STEPS);
   localparam int HALF_STEPS    = ANGLE_STEPS / 2;
   localparam int QUARTER_STEPS = ANGLE_STEPS / 4;
   localparam int QIDX_W        = $clog2(QUARTER_STEPS) + 1;

   // Trig coefficients are signed with TRIG_FRACTION_BITS fraction bits.
   localparam int TRIG_FRACTION_BITS = 14;
   localparam int TRIG_W             = TRIG_FRACTION_BITS + 2;
   localparam int PROD_W             = TRIG_W + COORD_W;
   localparam int SUM_W              = PROD_W + 1;
   localparam int QUOT_W             = SUM_W - TRIG_FRACTION_BITS;
   localparam int WIDE_W             = SUM_W;
   localparam longint TRUNC_BIAS     = (longint'(1) << TRIG_FRACTION_BITS) - 1;

   // Pi/2 in unsigned Q60, used to build the sine table, and its share per step.
   localparam longint unsigned HALF_PI_Q60      = 64'h1921FB54442D1847;
   localparam longint unsigned HALF_PI_STEP_Q60 = HALF_PI_Q60 / 64'(ANGLE_STEPS);

   // Register file.
   localparam int REG_COUNT  = 7;
   localparam int REG_IDX_W  = $clog2(REG_COUNT);
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [REG_IDX_W-1:0] reg_index_type;

   localparam reg_index_type REG_MAP_COLUMNS   = 3'd0;
   localparam reg_index_type REG_MAP_LINES     = 3'd1;
   localparam reg_index_type REG_SCALE         = 3'd2;
   localparam reg_index_type REG_HEIGHT_FACTOR = 3'd3;
   localparam reg_index_type REG_ANGLE_X       = 3'd4;
   localparam reg_index_type REG_ANGLE_Y       = 3'd5;
   localparam reg_index_type REG_ANGLE_Z       = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   typedef struct packed {
      trig_type sine;
      trig_type cosine;
   } trig_pair_type;

   typedef struct packed {
      logic              neg;
      logic [QIDX_W-1:0] idx;
   } trig_addr_type;

   // Clamp a wide signed value into the 32-bit coordinate range.
   function automatic coord_type sat_coord(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = {{(WIDE_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
      lo = {{(WIDE_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

   // Divide by 2^F with truncation toward zero, then saturate.
   function automatic coord_type trunc_coord(input sum_type v);
      sum_type                  bias;
      sum_type                  biased;
      logic signed [QUOT_W-1:0] q;
      bias   = v[SUM_W-1] ? SUM_W'(TRUNC_BIAS) : SUM_W'(0);
      biased = v + bias;
      q      = QUOT_W'(biased >>> TRIG_FRACTION_BITS);
      return sat_coord(WIDE_W'(q));
   endfunction

   // Fold an angle step onto the quarter-wave table: sign and table index.
   function automatic trig_addr_type trig_address(input logic [ANGLE_W-1:0] step);
      trig_addr_type         res;
      logic [ANGLE_W-2:0]    r;
      logic [ANGLE_W-1:0]    mirrored;
      res.neg  = step[ANGLE_W-1];
      r        = step[ANGLE_W-2:0];
      mirrored = ANGLE_W'(HALF_STEPS) - {1'b0, r};
      if ({1'b0, r} > ANGLE_W'(QUARTER_STEPS)) begin
         res.idx = mirrored[QIDX_W-1:0];
      end else begin
         res.idx = r[QIDX_W-1:0];
      end
      return res;
   endfunction

   // Unsigned quotient by shift and subtract; only used to build the table.
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quot;
      longint unsigned rem;
      quot = '0;
      rem  = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem     = rem - den;
            quot[b] = 1'b1;
         end
      end
      return quot;
   endfunction

   // Sine magnitude of table entry k, evaluated at elaboration with a Q30
   // Taylor series and rounded half up to TRIG_FRACTION_BITS.
   function automatic trig_type quarter_sine(input int unsigned k);
      longint unsigned phase;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned divisor;
      longint          sum;
      phase = 64'(k) << 2;
      x     = (HALF_PI_STEP_Q60 * phase + (64'd1 << 29)) >> 30;
      x2    = (x * x) >> 30;
      sum   = longint'(x);
      t     = x;
      for (int n = 1; n < 24; n++) begin
         if (t != 0) begin
            divisor = 64'(2 * n) * 64'(2 * n + 1);
            t       = udiv64((t * x2) >> 30, divisor);
            if (n[0]) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + (longint'(1) << (29 - TRIG_FRACTION_BITS))) >>> (30 - TRIG_FRACTION_BITS);
      return TRIG_W'(sum);
   endfunction

endpackage

### rtl/core/wfrot_rotate.sv
`timescale 1ns / 1ps

// One plane rotation: a' = c*a - s*b, b' = s*a + c*b, each divided by 2^F
// toward zero and saturated. Three register stages: products, sums, result.
module wfrot_rotate (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  wfrot_pkg::coord_type     up_a,
   input  wfrot_pkg::coord_type     up_b,
   input  wfrot_pkg::coord_type     up_keep,
   input  wfrot_pkg::trig_pair_type coef,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output wfrot_pkg::coord_type     dn_a,
   output wfrot_pkg::coord_type     dn_b,
   output wfrot_pkg::coord_type     dn_keep
);
   import wfrot_pkg::*;

   logic      p_valid_ff, s_valid_ff, r_valid_ff;
   logic      p_ready, s_ready, r_ready;
   prod_type  ca_ff, sb_ff, sa_ff, cb_ff;
   prod_type  ca_in, sb_in, sa_in, cb_in;
   coord_type p_keep_ff, s_keep_ff, r_keep_ff;
   sum_type   diff_ff, total_ff;
   sum_type   diff_in, total_in;
   coord_type ra_ff, rb_ff;
   coord_type ra_in, rb_in;

   // Each stage takes new data when it is empty or its item moves on.
   assign r_ready  = !r_valid_ff || dn_ready;
   assign s_ready  = !s_valid_ff || r_ready;
   assign p_ready  = !p_valid_ff || s_ready;
   assign up_ready = p_ready;

   // The four products of the coefficient pair with the two coordinates.
   always_comb begin
      ca_in = PROD_W'(coef.cosine) * PROD_W'(up_a);
      sb_in = PROD_W'(coef.sine) * PROD_W'(up_b);
      sa_in = PROD_W'(coef.sine) * PROD_W'(up_a);
      cb_in = PROD_W'(coef.cosine) * PROD_W'(up_b);
   end

   // Exact sums of the registered products.
   always_comb begin
      diff_in  = SUM_W'(ca_ff) - SUM_W'(sb_ff);
      total_in = SUM_W'(sa_ff) + SUM_W'(cb_ff);
   end

   // Scale back to integers and clamp to the coordinate range.
   always_comb begin
      ra_in = trunc_coord(diff_ff);
      rb_in = trunc_coord(total_ff);
   end

   // Valid bits follow the items through the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            p_valid_ff <= up_valid;
         end
         if (s_ready) begin
            s_valid_ff <= p_valid_ff;
         end
         if (r_ready) begin
            r_valid_ff <= s_valid_ff;
         end
      end
   end

   // Payload registers load whenever their stage is free to advance.
   always_ff @(posedge clock) begin
      if (p_ready) begin
         ca_ff     <= ca_in;
         sb_ff     <= sb_in;
         sa_ff     <= sa_in;
         cb_ff     <= cb_in;
         p_keep_ff <= up_keep;
      end
      if (s_ready) begin
         diff_ff   <= diff_in;
         total_ff  <= total_in;
         s_keep_ff <= p_keep_ff;
      end
      if (r_ready) begin
         ra_ff     <= ra_in;
         rb_ff     <= rb_in;
         r_keep_ff <= s_keep_ff;
      end
   end

   assign dn_valid = r_valid_ff;
   assign dn_a     = ra_ff;
   assign dn_b     = rb_ff;
   assign dn_keep  = r_keep_ff;

endmodule

### rtl/core/wireframe_point_rotate_xyz.sv
`timescale 1ns / 1ps

// Channel   Ports                                        Direction  Role
// --------  -------------------------------------------  ---------  ------------------
// req       req_valid/ready, point_col, point_row, height in         grid point in
// rsp       rsp_valid/ready, out_x, out_y, out_z          out        rotated point out
// csr       psel, penable, pwrite, paddr, pwdata, prdata  in/out     setup registers
//
// One point can be taken every cycle unless a stall on rsp has filled the pipeline; a point
// passes through twelve register stages (a centering stage, a scaling stage, three for
// each of the three rotations, one output stage) before rsp_valid rises. Every stage has
// its own valid bit and moves independently, so a stall on rsp fills empty stages
// before req_ready drops.
// Reset is synchronous: it clears the valid bits and sets the registers to
// their defaults. The trig coefficients are reloaded from the angle registers after a write.
module wireframe_point_rotate_xyz (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [wfrot_pkg::COL_W-1:0]            req_point_col,
   input  logic [wfrot_pkg::COL_W-1:0]            req_point_row,
   input  logic signed [wfrot_pkg::HEIGHT_W-1:0]  req_height,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [wfrot_pkg::COORD_W-1:0]   rsp_out_x,
   output logic signed [wfrot_pkg::COORD_W-1:0]   rsp_out_y,
   output logic signed [wfrot_pkg::COORD_W-1:0]   rsp_out_z,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [wfrot_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [wfrot_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [wfrot_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                   pready
);
   import wfrot_pkg::*;

   localparam int AXIS_COUNT = 3;
   localparam int AXIS_X     = 0;
   localparam int AXIS_Y     = 1;
   localparam int AXIS_Z     = 2;

   // Configuration registers.
   logic [MAP_W-1:0]    map_columns_ff, map_lines_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [FACTOR_W-1:0] height_factor_ff;
   logic [ANGLE_W-1:0]  angle_x_ff, angle_y_ff, angle_z_ff;
   logic                csr_write;
   reg_index_type       csr_index;

   // Trig coefficients and the quarter-wave table.
   trig_type            quarter_sine_w [QUARTER_STEPS+1];
   logic [ANGLE_W-1:0]  angle_w [AXIS_COUNT];
   trig_pair_type       trig_ff [AXIS_COUNT];
   trig_pair_type       trig_in [AXIS_COUNT];

   // Map centres.
   logic signed [DIFF_W-1:0] centre_x, centre_y;

   // Centering stage.
   logic                     s1_valid_ff, s1_ready;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic signed [HZ_W-1:0]   s1_hz_ff, s1_hz_in;

   // Scaling stage.
   logic                     s2_valid_ff, s2_ready;
   coord_type                s2_x_ff, s2_y_ff, s2_z_ff;
   coord_type                s2_x_in, s2_y_in, s2_z_in;
   logic signed [XS_W-1:0]   xs, ys;
   logic signed [ZS_W-1:0]   zs;
   logic signed [SCALE_W:0]  scale_s;

   // Rotation chain: x axis, then y, then z.
   logic      rx_valid, rx_ready, ry_valid, ry_ready, rz_valid, rz_ready;
   coord_type rx_y, rx_z, rx_x;
   coord_type ry_z, ry_x, ry_y;
   coord_type rz_x, rz_y, rz_z;

   // Output stage.
   logic      out_valid_ff, out_ready;
   coord_type out_x_ff, out_y_ff, out_z_ff;
   coord_type out_x_in, out_y_in;

   // Register writes complete on the access cycle of the APB transfer.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         map_columns_ff   <= MAP_W'(1);
         map_lines_ff     <= MAP_W'(1);
         scale_ff         <= SCALE_W'(1);
         height_factor_ff <= FACTOR_W'(1);
         angle_x_ff       <= '0;
         angle_y_ff       <= '0;
         angle_z_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAP_COLUMNS:   map_columns_ff   <= pwdata[MAP_W-1:0];
            REG_MAP_LINES:     map_lines_ff     <= pwdata[MAP_W-1:0];
            REG_SCALE:         scale_ff         <= pwdata[SCALE_W-1:0];
            REG_HEIGHT_FACTOR: height_factor_ff <= pwdata[FACTOR_W-1:0];
            REG_ANGLE_X:       angle_x_ff       <= pwdata[ANGLE_W-1:0];
            REG_ANGLE_Y:       angle_y_ff       <= pwdata[ANGLE_W-1:0];
            REG_ANGLE_Z:       angle_z_ff       <= pwdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_MAP_COLUMNS:   prdata = CSR_DATA_W'(map_columns_ff);
         REG_MAP_LINES:     prdata = CSR_DATA_W'(map_lines_ff);
         REG_SCALE:         prdata = CSR_DATA_W'(scale_ff);
         REG_HEIGHT_FACTOR: prdata = CSR_DATA_W'(height_factor_ff);
         REG_ANGLE_X:       prdata = CSR_DATA_W'(angle_x_ff);
         REG_ANGLE_Y:       prdata = CSR_DATA_W'(angle_y_ff);
         REG_ANGLE_Z:       prdata = CSR_DATA_W'(angle_z_ff);
         default:           prdata = '0;
      endcase
   end

   // Quarter-wave sine table, fixed at elaboration.
   for (genvar k = 0; k <= QUARTER_STEPS; k++) begin : g_sine
      localparam trig_type SINE_VALUE = quarter_sine(k);
      assign quarter_sine_w[k] = SINE_VALUE;
   end

   assign angle_w[AXIS_X] = angle_x_ff;
   assign angle_w[AXIS_Y] = angle_y_ff;
   assign angle_w[AXIS_Z] = angle_z_ff;

   // Sine and cosine of each angle; cosine is sine a quarter turn later.
   always_comb begin : trig_lookup
      trig_addr_type sin_addr;
      trig_addr_type cos_addr;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         sin_addr = trig_address(angle_w[i]);
         cos_addr = trig_address(angle_w[i] + ANGLE_W'(QUARTER_STEPS));
         trig_in[i].sine   = sin_addr.neg ? -quarter_sine_w[sin_addr.idx]
                                          : quarter_sine_w[sin_addr.idx];
         trig_in[i].cosine = cos_addr.neg ? -quarter_sine_w[cos_addr.idx]
                                          : quarter_sine_w[cos_addr.idx];
      end
   end

   always_ff @(posedge clock) begin
      trig_ff <= trig_in;
   end

   // Centres are floor((n - 1) / 2), which is -1 for an empty map.
   assign centre_x = ($signed({1'b0, map_columns_ff}) - DIFF_W'(1)) >>> 1;
   assign centre_y = ($signed({1'b0, map_lines_ff}) - DIFF_W'(1)) >>> 1;

   // Stage ready chain, from the output back to the input.
   assign out_ready = !out_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || rx_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // Centre the column and row; apply the height factor.
   always_comb begin
      s1_dx_in = $signed({2'b00, req_point_col}) - centre_x;
      s1_dy_in = $signed({2'b00, req_point_row}) - centre_y;
      s1_hz_in = HZ_W'(req_height) * HZ_W'($signed(height_factor_ff));
   end

   // Apply the zoom to all three coordinates.
   always_comb begin
      scale_s = $signed({1'b0, scale_ff});
      xs      = XS_W'(s1_dx_ff) * XS_W'(scale_s);
      ys      = XS_W'(s1_dy_ff) * XS_W'(scale_s);
      zs      = ZS_W'(s1_hz_ff) * ZS_W'(scale_s);
      s2_x_in = COORD_W'(xs);
      s2_y_in = COORD_W'(ys);
      s2_z_in = COORD_W'(zs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
         s1_hz_ff <= s1_hz_in;
      end
      if (s2_ready) begin
         s2_x_ff <= s2_x_in;
         s2_y_ff <= s2_y_in;
         s2_z_ff <= s2_z_in;
      end
   end

   // Rotation about x: (y, z) turn, x rides along.
   wfrot_rotate u_rotate_x (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid_ff),
      .up_ready (rx_ready),
      .up_a     (s2_y_ff),
      .up_b     (s2_z_ff),
      .up_keep  (s2_x_ff),
      .coef     (trig_ff[AXIS_X]),
      .dn_valid (rx_valid),
      .dn_ready (ry_ready),
      .dn_a     (rx_y),
      .dn_b     (rx_z),
      .dn_keep  (rx_x)
   );

   // Rotation about y: (z, x) turn, y rides along.
   wfrot_rotate u_rotate_y (
      .clock    (clock),
      .reset    (reset),
      .up_valid (rx_valid),
      .up_ready (ry_ready),
      .up_a     (rx_z),
      .up_b     (rx_x),
      .up_keep  (rx_y),
      .coef     (trig_ff[AXIS_Y]),
      .dn_valid (ry_valid),
      .dn_ready (rz_ready),
      .dn_a     (ry_z),
      .dn_b     (ry_x),
      .dn_keep  (ry_y)
   );

   // Rotation about z: (x, y) turn, z rides along.
   wfrot_rotate u_rotate_z (
      .clock    (clock),
      .reset    (reset),
      .up_valid (ry_valid),
      .up_ready (rz_ready),
      .up_a     (ry_x),
      .up_b     (ry_y),
      .up_keep  (ry_z),
      .coef     (trig_ff[AXIS_Z]),
      .dn_valid (rz_valid),
      .dn_ready (out_ready),
      .dn_a     (rz_x),
      .dn_b     (rz_y),
      .dn_keep  (rz_z)
   );

   // Move x and y back by the map centre and saturate; z passes through.
   always_comb begin
      out_x_in = sat_coord(WIDE_W'(rz_x) + WIDE_W'(centre_x));
      out_y_in = sat_coord(WIDE_W'(rz_y) + WIDE_W'(centre_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= rz_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= rz_z;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_z = out_z_ff;

endmodule

### rtl/core/wfrot_port_checker.sv
`timescale 1ns / 1ps

// Watches the ports of the point transform.
module wfrot_port_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic [wfrot_pkg::COL_W-1:0]            req_point_col,
   input logic [wfrot_pkg::COL_W-1:0]            req_point_row,
   input logic signed [wfrot_pkg::HEIGHT_W-1:0]  req_height,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [wfrot_pkg::COORD_W-1:0]   rsp_out_x,
   input logic signed [wfrot_pkg::COORD_W-1:0]   rsp_out_y,
   input logic signed [wfrot_pkg::COORD_W-1:0]   rsp_out_z,
   input logic                                   psel,
   input logic                                   penable,
   input logic                                   pwrite,
   input logic [wfrot_pkg::CSR_ADDR_W-1:0]       paddr,
   input logic [wfrot_pkg::CSR_DATA_W-1:0]       pwdata,
   input logic [wfrot_pkg::CSR_DATA_W-1:0]       prdata,
   input logic                                   pready
);
   import wfrot_pkg::*;

   // A waiting input keeps its valid and its fields until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_point_col)
         && $stable(req_point_row) && $stable(req_height))
      else $error("waiting input changed");

   // A stalled result keeps its valid and its coordinates.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z))
      else $error("stalled result changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the output side taking transfers, every stage can advance.
   assert property (@(posedge clock) !reset && rsp_ready |-> req_ready)
      else $error("input stalled while output is ready");

   // A write to the x angle reads back on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      !reset && psel && penable && pwrite && pready
         && paddr[CSR_ADDR_W-1:2] == REG_ANGLE_X
      |=> paddr[CSR_ADDR_W-1:2] != REG_ANGLE_X
         || prdata == CSR_DATA_W'($past(pwdata[ANGLE_W-1:0])))
      else $error("angle register read-back mismatch");

endmodule

bind wireframe_point_rotate_xyz wfrot_port_checker u_port_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_point_col (req_point_col),
   .req_point_row (req_point_row),
   .req_height    (req_height),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_x     (rsp_out_x),
   .rsp_out_y     (rsp_out_y),
   .rsp_out_z     (rsp_out_z),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pwdata        (pwdata),
   .prdata        (prdata),
   .pready        (pready)
);

### tb/sv/tb_wireframe_point_rotate_xyz.sv
`timescale 1ns / 1ps

module tb_wireframe_point_rotate_xyz;
   import wfrot_pkg::*;

   // Angle and coefficient format of the rotation.
   localparam longint unsigned QUARTER_TURN = 64'd1024;
   localparam int              COEFF_FRAC   = 14;
   localparam longint unsigned PI_HALF_Q60  = 64'h1921FB54442D1847;

   // Run control.
   localparam int CYCLE_LIMIT      = 200000;
   localparam int PIPE_SETTLE      = 16;
   localparam int LONG_HOLD        = 150;
   localparam int IDLE_PERCENT     = 33;
   localparam int POINTS_PER_PHASE = 120;
   localparam int RANDOM_PHASES    = 12;
   localparam int STEADY_PHASE     = 3;
   localparam int HOLD_PHASE       = 5;
   localparam int UNUSED_REG_INDEX = REG_COUNT;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
   } rotated_point_type;

   // Holds the register copy, the coefficient tables and the rotated points
   // that are still due on the result channel.
   class point_rotation_checker;
      logic [10:0]        map_columns;
      logic [10:0]        map_lines;
      logic [7:0]         scale;
      logic signed [7:0]  height_factor;
      logic [9:0]         angle_x;
      logic [9:0]         angle_y;
      logic [9:0]         angle_z;
      longint             sine_step[1024];
      longint             cosine_step[1024];
      rotated_point_type  rotated_queue[$];
      int                 mismatches;

      function new();
         map_columns   = 11'd1;
         map_lines     = 11'd1;
         scale         = 8'd1;
         height_factor = 8'sd1;
         angle_x       = '0;
         angle_y       = '0;
         angle_z       = '0;
         mismatches    = 0;
         for (int k = 0; k < 1024; k++) begin
            sine_step[k]   = wave_value(4 * longint'(k));
            cosine_step[k] = wave_value(4 * longint'(k) + QUARTER_TURN);
         end
      endfunction

      // Sine in quarter steps: fold onto the first quarter, evaluate the Taylor
      // series in Q30 and round half up to the coefficient format.
      function longint wave_value(longint unsigned phase);
         bit              negate;
         longint unsigned arg;
         longint unsigned arg_sq;
         longint unsigned term;
         longint          total;
         negate = 1'b0;
         phase  = phase % (4 * QUARTER_TURN);
         if (phase >= 2 * QUARTER_TURN) begin
            negate = 1'b1;
            phase  = phase - 2 * QUARTER_TURN;
         end
         if (phase > QUARTER_TURN) begin
            phase = 2 * QUARTER_TURN - phase;
         end
         arg    = ((PI_HALF_Q60 / QUARTER_TURN) * phase + (64'd1 << 29)) >> 30;
         arg_sq = (arg * arg) >> 30;
         total  = longint'(arg);
         term   = arg;
         for (int n = 1; n < 24 && term != 0; n++) begin
            term = ((term * arg_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               total = total - longint'(term);
            end else begin
               total = total + longint'(term);
            end
         end
         if (total < 0) begin
            total = 0;
         end
         total = (total + (longint'(1) << (29 - COEFF_FRAC))) >>> (30 - COEFF_FRAC);
         return negate ? -total : total;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // One rotated coordinate: exact sum of products, divided by 2^F toward zero and clamped.
      function longint blend(longint c, longint a, longint s, longint b);
         longint sum;
         sum = c * a + s * b;
         return clamp32(sum / (longint'(1) << COEFF_FRAC));
      endfunction

      function void set_register(int idx, logic [31:0] value);
         case (idx)
            REG_MAP_COLUMNS:   map_columns   = value[10:0];
            REG_MAP_LINES:     map_lines     = value[10:0];
            REG_SCALE:         scale         = value[7:0];
            REG_HEIGHT_FACTOR: height_factor = value[7:0];
            REG_ANGLE_X:       angle_x       = value[9:0];
            REG_ANGLE_Y:       angle_y       = value[9:0];
            REG_ANGLE_Z:       angle_z       = value[9:0];
            default: ;
         endcase
      endfunction

      // Center the point, apply the height factor and scale, rotate about x, y, then z, and un-center x and y.
      function void note_point(logic [9:0] col, logic [9:0] row, logic signed [15:0] h);
         longint            cx;
         longint            cy;
         longint            px;
         longint            py;
         longint            pz;
         longint            nx;
         longint            ny;
         longint            nz;
         longint            c;
         longint            s;
         rotated_point_type point;
         cx = (longint'(map_columns) - 1) >>> 1;
         cy = (longint'(map_lines) - 1) >>> 1;
         px = (longint'(col) - cx) * longint'(scale);
         py = (longint'(row) - cy) * longint'(scale);
         pz = longint'(h) * longint'(height_factor) * longint'(scale);

         c  = cosine_step[angle_x];
         s  = sine_step[angle_x];
         ny = blend(c, py, -s, pz);
         nz = blend(s, py, c, pz);
         py = ny;
         pz = nz;

         c  = cosine_step[angle_y];
         s  = sine_step[angle_y];
         nz = blend(-s, px, c, pz);
         nx = blend(c, px, s, pz);
         px = nx;
         pz = nz;

         c  = cosine_step[angle_z];
         s  = sine_step[angle_z];
         nx = blend(c, px, -s, py);
         ny = blend(s, px, c, py);

         point.x = coord_type'(clamp32(nx + cx));
         point.y = coord_type'(clamp32(ny + cy));
         point.z = coord_type'(pz);
         rotated_queue.push_back(point);
      endfunction

      function void check_point(coord_type x, coord_type y, coord_type z);
         rotated_point_type want;
         if (rotated_queue.size() == 0) begin
            $error("rotated point with none pending: x=%0d y=%0d z=%0d", x, y, z);
            mismatches++;
            return;
         end
         want = rotated_queue.pop_front();
         if (x !== want.x) begin
            $error("out_x: expected %0d, actual %0d", want.x, x);
            mismatches++;
         end
         if (y !== want.y) begin
            $error("out_y: expected %0d, actual %0d", want.y, y);
            mismatches++;
         end
         if (z !== want.z) begin
            $error("out_z: expected %0d, actual %0d", want.z, z);
            mismatches++;
         end
      endfunction

      function int pending_count();
         return rotated_queue.size();
      endfunction
   endclass

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic [COL_W-1:0]             req_point_col = '0;
   logic [COL_W-1:0]             req_point_row = '0;
   logic signed [HEIGHT_W-1:0]   req_height    = '0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b0;
   coord_type                    rsp_out_x;
   coord_type                    rsp_out_y;
   coord_type                    rsp_out_z;
   logic                         psel          = 1'b0;
   logic                         penable       = 1'b0;
   logic                         pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0]        paddr         = '0;
   logic [CSR_DATA_W-1:0]        pwdata        = '0;
   logic [CSR_DATA_W-1:0]        prdata;
   logic                         pready;

   logic                         gaps_on       = 1'b1;
   logic                         stall_request = 1'b0;
   int                           cycle_count   = 0;
   point_rotation_checker        board;

   wireframe_point_rotate_xyz u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_point_col (req_point_col),
      .req_point_row (req_point_row),
      .req_height    (req_height),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #5 clock = ~clock;

   // Setup cycle, then access cycle; the bus is left selected for a following write.
   task automatic write_register(input int idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx << 2);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      board.set_register(idx, value);
   endtask

   task automatic park_bus();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int cols, input int lines, input int zoom,
                                input int factor, input int ax, input int ay, input int az);
      write_register(REG_MAP_COLUMNS, 32'(cols));
      write_register(REG_MAP_LINES, 32'(lines));
      write_register(REG_SCALE, 32'(zoom));
      write_register(REG_HEIGHT_FACTOR, 32'(factor));
      write_register(REG_ANGLE_X, 32'(ax));
      write_register(REG_ANGLE_Y, 32'(ay));
      write_register(REG_ANGLE_Z, 32'(az));
      park_bus();
   endtask

   // Offer one point, idling first at random, and hold it until the transfer.
   task automatic send_point(input logic [9:0] col, input logic [9:0] row,
                             input logic signed [15:0] h);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_point_col <= col;
      req_point_row <= row;
      req_height    <= h;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      board.note_point(col, row, h);
   endtask

   task automatic send_random_point();
      logic signed [15:0] h;
      case ($urandom_range(9))
         0:       h = 16'sh8000;
         1:       h = 16'sh7FFF;
         2, 3:    h = 16'(int'($urandom_range(0, 600)) - 300);
         default: h = 16'($urandom);
      endcase
      send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), h);
   endtask

   // Field extremes plus one random point.
   task automatic send_edge_points();
      send_point(10'd0, 10'd0, 16'sd0);
      send_point(10'd1023, 10'd1023, 16'sh7FFF);
      send_point(10'd0, 10'd1023, 16'sh8000);
      send_point(10'd1023, 10'd0, -16'sd1);
      send_random_point();
   endtask

   // Stop offering, let every rotated point come back, then let the pipe settle.
   task automatic drain_points();
      req_valid <= 1'b0;
      while (board.pending_count() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // Result side: check each transfer and drive ready, with an optional long hold.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            board.check_point(rsp_out_x, rsp_out_y, rsp_out_z);
         end
         if (stall_request) begin
            hold_left = LONG_HOLD;
            stall_request <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_wireframe_point_rotate_xyz NOT OK");
      $finish;
   end

   initial begin
      int zoom;
      int factor;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults first, then the corner settings.
      send_edge_points();
      drain_points();
      apply_setting(1024, 1024, 255, 127, 0, 256, 512);
      send_edge_points();
      drain_points();
      apply_setting(0, 2047, 0, -128, 1023, 1023, 1023);
      send_edge_points();
      drain_points();
      apply_setting(2047, 0, 255, -128, 128, 768, 384);
      send_edge_points();
      drain_points();

      // A write past the last register must leave the setting untouched.
      write_register(UNUSED_REG_INDEX, $urandom);
      park_bus();
      send_edge_points();
      drain_points();

      // Random settings, each followed by a burst of random points.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         zoom   = ($urandom_range(9) == 0) ? int'($urandom_range(0, 255))
                                           : int'($urandom_range(1, 255));
         factor = ($urandom_range(99) < 80) ? int'($urandom_range(0, 128)) - 64
                                            : int'($urandom_range(0, 255)) - 128;
         apply_setting(($urandom_range(99) < 80) ? $urandom_range(1, 1024)
                                                 : $urandom_range(0, 2047),
                       ($urandom_range(99) < 80) ? $urandom_range(1, 1024)
                                                 : $urandom_range(0, 2047),
                       zoom, factor,
                       ($urandom_range(3) == 0) ? 128 * $urandom_range(0, 7)
                                                : $urandom_range(0, 1023),
                       ($urandom_range(3) == 0) ? 128 * $urandom_range(0, 7)
                                                : $urandom_range(0, 1023),
                       ($urandom_range(3) == 0) ? 128 * $urandom_range(0, 7)
                                                : $urandom_range(0, 1023));
         gaps_on = (phase != STEADY_PHASE);
         if (phase == HOLD_PHASE) begin
            stall_request <= 1'b1;
         end
         repeat (POINTS_PER_PHASE) send_random_point();
         drain_points();
      end

      if (board.mismatches == 0 && board.pending_count() == 0) begin
         $display("tb_wireframe_point_rotate_xyz OK");
      end else begin
         $display("tb_wireframe_point_rotate_xyz NOT OK");
      end
      $finish;
   end

endmodule
